// ----- rtl/whtp_pkg.sv -----
package whtp_pkg;

	localparam int unsigned HeadW = 13;
	localparam int unsigned ErrW = 13;
	localparam int unsigned DerivW = 14;
	localparam int unsigned SumW = 18;
	localparam int unsigned SettleW = 11;
	localparam int unsigned TickW = 17;
	localparam int unsigned DriveW = 8;
	localparam int unsigned CfgDataW = 16;

	localparam int unsigned WrapBias = 8640;
	localparam int unsigned FullTurn = 5760;
	localparam int unsigned HalfTurn = 2880;
	localparam int unsigned IntegWindow = 480;
	localparam int unsigned SumMax = 131071;
	localparam int unsigned SettleSat = 1024;

	localparam logic [15:0] PropGainRst = 16'd422;
	localparam logic [15:0] IntegGainRst = 16'd0;
	localparam logic [15:0] DerivGainRst = 16'd2048;
	localparam logic [15:0] IntegLimitRst = 16'd8000;
	localparam logic [6:0] TopSpeedRst = 7'd127;
	localparam logic [11:0] SettleThreshRst = 12'd16;
	localparam logic [9:0] SettleLimitRst = 10'd50;
	localparam logic [15:0] TimeoutRst = 16'd500;

	typedef enum logic [2:0] {
		RegPropGain = 3'd0,
		RegIntegGain = 3'd1,
		RegDerivGain = 3'd2,
		RegIntegLimit = 3'd3,
		RegTopSpeed = 3'd4,
		RegSettleThresh = 3'd5,
		RegSettleLimit = 3'd6,
		RegTimeout = 3'd7
	} cfg_reg_t;

endpackage

// ----- rtl/wrapped_heading_turn_pid.sv -----
// a result passes the input stage, the second stage and the output register in turn
// throughput: one sample per cycle unless out_ready stalls the output; controller state
// updates as a sample leaves the input stage; the second stage holds the three gain multiplies,
// the sum and the output clamp; reset: gains and limits return to their defaults, controller
// state and counters clear, and all pipeline stages come up empty
module wrapped_heading_turn_pid (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [whtp_pkg::HeadW-1:0]              target_heading,
	input  logic [whtp_pkg::HeadW-1:0]              measured_heading,
	input  logic                                    start_move,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [whtp_pkg::DriveW-1:0]      left_drive,
	output logic signed [whtp_pkg::DriveW-1:0]      right_drive,
	output logic signed [whtp_pkg::ErrW-1:0]        heading_error,
	output logic                                    done_res,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [2:0]                              cfg_index,
	input  logic [whtp_pkg::CfgDataW-1:0]           cfg_data
);

	logic [15:0] kp_q, ki_q, kd_q, ilim_q, timeout_q;
	logic [6:0] top_q;
	logic [11:0] thresh_q;
	logic [9:0] slimit_q;

	logic signed [whtp_pkg::ErrW-1:0] prev_q;
	logic signed [whtp_pkg::SumW-1:0] sum_q;
	logic [whtp_pkg::SettleW-1:0] settled_q;
	logic [whtp_pkg::TickW-1:0] tick_q;

	logic v_s1;
	logic [whtp_pkg::HeadW-1:0] tgt_s1, meas_s1;
	logic start_s1;

	logic v_s2;
	logic signed [whtp_pkg::ErrW-1:0] err_s2;
	logic signed [whtp_pkg::DerivW-1:0] deriv_s2;
	logic signed [whtp_pkg::SumW-1:0] sum_s2;
	logic done_s2;

	logic out_valid_q, done_q;
	logic signed [whtp_pkg::DriveW-1:0] left_q, right_q;
	logic signed [whtp_pkg::ErrW-1:0] err_q;

	logic out_free, s2_free, s1_move;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign s2_free = !v_s2 || out_free;
	assign s1_move = v_s1 && s2_free;
	assign in_ready = !v_s1 || s2_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= whtp_pkg::PropGainRst;
			ki_q <= whtp_pkg::IntegGainRst;
			kd_q <= whtp_pkg::DerivGainRst;
			ilim_q <= whtp_pkg::IntegLimitRst;
			top_q <= whtp_pkg::TopSpeedRst;
			thresh_q <= whtp_pkg::SettleThreshRst;
			slimit_q <= whtp_pkg::SettleLimitRst;
			timeout_q <= whtp_pkg::TimeoutRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (whtp_pkg::cfg_reg_t'(cfg_index))
				whtp_pkg::RegPropGain: kp_q <= cfg_data[15:0];
				whtp_pkg::RegIntegGain: ki_q <= cfg_data[15:0];
				whtp_pkg::RegDerivGain: kd_q <= cfg_data[15:0];
				whtp_pkg::RegIntegLimit: ilim_q <= cfg_data[15:0];
				whtp_pkg::RegTopSpeed: top_q <= cfg_data[6:0];
				whtp_pkg::RegSettleThresh: thresh_q <= cfg_data[11:0];
				whtp_pkg::RegSettleLimit: slimit_q <= cfg_data[9:0];
				whtp_pkg::RegTimeout: timeout_q <= cfg_data[15:0];
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tgt_s1 <= target_heading;
			meas_s1 <= measured_heading;
			start_s1 <= start_move;
		end
	end

	// error wrap, integral and done
	logic [14:0] diff_w;
	logic [12:0] rem_w;
	logic signed [whtp_pkg::ErrW-1:0] err_w, prev_eff;
	logic [11:0] mag_w;
	logic signed [whtp_pkg::DerivW-1:0] deriv_w;
	logic signed [whtp_pkg::SumW:0] sum_base, sum_add, sum_cl, sum_sat, lim_w;
	logic signed [whtp_pkg::SumW-1:0] sum_eff, sum_new;
	logic [whtp_pkg::SettleW-1:0] settled_eff, settled_new;
	logic [whtp_pkg::TickW-1:0] tick_eff, tick_new;
	logic timed_out, done_w;

	always_comb begin
		diff_w = 15'(tgt_s1) - 15'(meas_s1) + 15'(whtp_pkg::WrapBias);
		if (diff_w >= 15'(2 * whtp_pkg::FullTurn)) begin
			rem_w = 13'(diff_w - 15'(2 * whtp_pkg::FullTurn));
		end else if (diff_w >= 15'(whtp_pkg::FullTurn)) begin
			rem_w = 13'(diff_w - 15'(whtp_pkg::FullTurn));
		end else begin
			rem_w = 13'(diff_w);
		end
		err_w = $signed(rem_w - 13'(whtp_pkg::HalfTurn));
		mag_w = err_w[12] ? 12'(-err_w) : 12'(err_w);

		prev_eff = start_s1 ? '0 : prev_q;
		sum_eff = start_s1 ? '0 : sum_q;
		settled_eff = start_s1 ? '0 : settled_q;
		tick_eff = start_s1 ? '0 : tick_q;

		deriv_w = 14'(err_w) - 14'(prev_eff);

		sum_base = 19'(sum_eff);
		sum_add = (mag_w < 12'(whtp_pkg::IntegWindow)) ? sum_base + 19'(err_w) : sum_base;
		lim_w = $signed({3'b000, ilim_q});
		if (err_w > 13'sd0) begin
			sum_cl = (sum_add > lim_w) ? lim_w : sum_add;
		end else begin
			sum_cl = (sum_add < -lim_w) ? -lim_w : sum_add;
		end
		if (sum_cl > 19'sd131071) begin
			sum_sat = 19'(whtp_pkg::SumMax);
		end else if (sum_cl < -19'sd131071) begin
			sum_sat = -19'(whtp_pkg::SumMax);
		end else begin
			sum_sat = sum_cl;
		end
		sum_new = sum_sat[whtp_pkg::SumW-1:0];

		timed_out = tick_eff > {1'b0, timeout_q};
		tick_new = (&tick_eff) ? tick_eff : tick_eff + 1'b1;
		if (mag_w < thresh_q && settled_eff < 11'(whtp_pkg::SettleSat)) begin
			settled_new = settled_eff + 1'b1;
		end else begin
			settled_new = settled_eff;
		end
		done_w = timed_out || (settled_new > {1'b0, slimit_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q <= '0;
			settled_q <= '0;
			tick_q <= '0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_move) begin
				prev_q <= err_w;
				sum_q <= sum_new;
				settled_q <= settled_new;
				tick_q <= tick_new;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			err_s2 <= err_w;
			deriv_s2 <= deriv_w;
			sum_s2 <= sum_new;
			done_s2 <= done_w;
		end
	end

	// gain products, scaling and clamp
	logic signed [29:0] p_prod;
	logic signed [30:0] d_prod;
	logic signed [34:0] i_prod;
	logic signed [35:0] acc_w, acc_adj;
	logic signed [23:0] quot_w, top_w;
	logic signed [whtp_pkg::DriveW-1:0] speed_w;

	always_comb begin
		p_prod = err_s2 * $signed({1'b0, kp_q});
		d_prod = deriv_s2 * $signed({1'b0, kd_q});
		i_prod = sum_s2 * $signed({1'b0, ki_q});
		acc_w = 36'(p_prod) + 36'(d_prod) + 36'(i_prod);
		acc_adj = acc_w[35] ? acc_w + 36'sd4095 : acc_w;
		quot_w = acc_adj[35:12];
		top_w = $signed({17'b0, top_q});
		if (quot_w > top_w) begin
			speed_w = 8'(top_w);
		end else if (quot_w < -top_w) begin
			speed_w = 8'(-top_w);
		end else begin
			speed_w = 8'(quot_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			left_q <= speed_w;
			right_q <= -speed_w;
			err_q <= err_s2;
			done_q <= done_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign left_drive = left_q;
	assign right_drive = right_q;
	assign heading_error = err_q;
	assign done_res = done_q;

endmodule

// ----- rtl/whtp_checker.sv -----
module whtp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [whtp_pkg::DriveW-1:0]   left_drive,
	input logic signed [whtp_pkg::DriveW-1:0]   right_drive,
	input logic signed [whtp_pkg::ErrW-1:0]     heading_error,
	input logic                                 done_res
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive)
			&& $stable(heading_error) && $stable(done_res))
		else $error("result changed while stalled");

	// right side always mirrors left side
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> right_drive == -left_drive)
		else $error("right drive is not the negated left drive");

	// wrapped error stays inside half a turn
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading_error >= -13'sd2880) && (heading_error <= 13'sd2879))
		else $error("heading error outside wrap range");

	// drive magnitude never goes past the seven-bit limit
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_drive != -8'sd128)
		else $error("drive value out of range");

endmodule

bind wrapped_heading_turn_pid whtp_checker u_whtp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.left_drive(left_drive),
	.right_drive(right_drive),
	.heading_error(heading_error),
	.done_res(done_res)
);

// ----- dv/wrapped_heading_turn_pid_tb.sv -----
`timescale 1ns / 1ps

module wrapped_heading_turn_pid_tb;

	typedef struct packed {
		logic [whtp_pkg::HeadW-1:0] tgt;
		logic [whtp_pkg::HeadW-1:0] meas;
		logic                       start;
	} heading_sample_t;

	typedef struct packed {
		logic signed [whtp_pkg::DriveW-1:0] left;
		logic signed [whtp_pkg::DriveW-1:0] right;
		logic signed [whtp_pkg::ErrW-1:0]   err;
		logic                               done;
	} drive_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [whtp_pkg::HeadW-1:0]         target_heading = '0;
	logic [whtp_pkg::HeadW-1:0]         measured_heading = '0;
	logic                               start_move = 1'b0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [whtp_pkg::DriveW-1:0] left_drive;
	logic signed [whtp_pkg::DriveW-1:0] right_drive;
	logic signed [whtp_pkg::ErrW-1:0]   heading_error;
	logic                               done_res;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [2:0]                         cfg_index = '0;
	logic [whtp_pkg::CfgDataW-1:0]      cfg_data = '0;

	heading_sample_t heading_samples[$];
	drive_result_t   drive_expected[$];
	heading_sample_t next_sample;
	heading_sample_t taken_sample;
	drive_result_t   oldest;
	bit              steady = 1'b0;
	int unsigned     mismatches = 0;

	// register shadow
	logic [15:0] kp = whtp_pkg::PropGainRst;
	logic [15:0] ki = whtp_pkg::IntegGainRst;
	logic [15:0] kd = whtp_pkg::DerivGainRst;
	logic [15:0] ilim = whtp_pkg::IntegLimitRst;
	logic [6:0]  top = whtp_pkg::TopSpeedRst;
	logic [11:0] thresh = whtp_pkg::SettleThreshRst;
	logic [9:0]  slimit = whtp_pkg::SettleLimitRst;
	logic [15:0] tmo = whtp_pkg::TimeoutRst;

	// controller state
	int prev_err = 0;
	int integ_sum = 0;
	int settled = 0;
	int ticks = 0;

	wrapped_heading_turn_pid u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.target_heading   (target_heading),
		.measured_heading (measured_heading),
		.start_move       (start_move),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.left_drive       (left_drive),
		.right_drive      (right_drive),
		.heading_error    (heading_error),
		.done_res         (done_res),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic drive_result_t predict_drive(heading_sample_t s);
		int            e;
		int            d;
		int            mag;
		int            lim;
		longint        acc;
		longint        speed;
		longint        neg;
		bit            timed_out;
		drive_result_t r;
		if (s.start) begin
			prev_err = 0;
			integ_sum = 0;
			settled = 0;
			ticks = 0;
		end
		e = ((int'(s.tgt) - int'(s.meas) + int'(whtp_pkg::WrapBias))
			% int'(whtp_pkg::FullTurn)) - int'(whtp_pkg::HalfTurn);
		d = e - prev_err;
		mag = (e < 0) ? -e : e;
		if (mag < int'(whtp_pkg::IntegWindow))
			integ_sum += e;
		lim = int'(ilim);
		if (e > 0) begin
			if (integ_sum > lim)
				integ_sum = lim;
		end else if (integ_sum < -lim) begin
			integ_sum = -lim;
		end
		if (integ_sum > int'(whtp_pkg::SumMax))
			integ_sum = int'(whtp_pkg::SumMax);
		if (integ_sum < -int'(whtp_pkg::SumMax))
			integ_sum = -int'(whtp_pkg::SumMax);
		acc = longint'(e) * longint'(kp) + longint'(d) * longint'(kd)
			+ longint'(integ_sum) * longint'(ki);
		speed = acc / 4096;
		if (speed > longint'(top))
			speed = longint'(top);
		else if (speed < -longint'(top))
			speed = -longint'(top);
		prev_err = e;
		timed_out = ticks > int'(tmo);
		if (ticks < (2 ** whtp_pkg::TickW) - 1)
			ticks++;
		if (mag < int'(thresh) && settled < int'(whtp_pkg::SettleSat))
			settled++;
		neg = -speed;
		r.left = speed[whtp_pkg::DriveW-1:0];
		r.right = neg[whtp_pkg::DriveW-1:0];
		r.err = e[whtp_pkg::ErrW-1:0];
		r.done = timed_out || settled > int'(slimit);
		return r;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				taken_sample.tgt = target_heading;
				taken_sample.meas = measured_heading;
				taken_sample.start = start_move;
				drive_expected.push_back(predict_drive(taken_sample));
			end
			if (heading_samples.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
				next_sample = heading_samples.pop_front();
				in_valid <= 1'b1;
				target_heading <= next_sample.tgt;
				measured_heading <= next_sample.meas;
				start_move <= next_sample.start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_expected.size() == 0) begin
					$error("result transfer with nothing expected");
					mismatches++;
				end else begin
					oldest = drive_expected.pop_front();
					if (left_drive !== oldest.left) begin
						$error("left_drive: expected %0d, got %0d", oldest.left, left_drive);
						mismatches++;
					end
					if (right_drive !== oldest.right) begin
						$error("right_drive: expected %0d, got %0d", oldest.right, right_drive);
						mismatches++;
					end
					if (heading_error !== oldest.err) begin
						$error("heading_error: expected %0d, got %0d", oldest.err,
							heading_error);
						mismatches++;
					end
					if (done_res !== oldest.done) begin
						$error("done_res: expected %0d, got %0d", oldest.done, done_res);
						mismatches++;
					end
				end
			end
			out_ready <= steady || ($urandom_range(99) >= 24);
		end
	end

	task automatic write_reg(whtp_pkg::cfg_reg_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			whtp_pkg::RegPropGain: kp = val;
			whtp_pkg::RegIntegGain: ki = val;
			whtp_pkg::RegDerivGain: kd = val;
			whtp_pkg::RegIntegLimit: ilim = val;
			whtp_pkg::RegTopSpeed: top = val[6:0];
			whtp_pkg::RegSettleThresh: thresh = val[11:0];
			whtp_pkg::RegSettleLimit: slimit = val[9:0];
			whtp_pkg::RegTimeout: tmo = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (heading_samples.size() != 0 || in_valid || drive_expected.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic void add_sample(int t, int m, bit s);
		heading_sample_t h;
		h.tgt = t[whtp_pkg::HeadW-1:0];
		h.meas = m[whtp_pkg::HeadW-1:0];
		h.start = s;
		heading_samples.push_back(h);
	endfunction

	// a turn: usually a start, then the gyro closes in on the target with some noise
	task automatic queue_turn(int n);
		int tgt;
		int meas;
		int e;
		tgt = $urandom_range(0, 5759);
		meas = $urandom_range(0, 5759);
		for (int i = 0; i < n; i++) begin
			add_sample(tgt, meas, i == 0 && $urandom_range(9) != 0);
			e = ((tgt - meas + 8640) % 5760) - 2880;
			meas = (meas + e * int'($urandom_range(1, 6)) / 8
				+ int'($urandom_range(0, 8)) - 4 + 11520) % 5760;
			if ($urandom_range(19) == 0)
				tgt = $urandom_range(0, 5759);
		end
	endtask

	task automatic queue_random(int count);
		int n;
		int k;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 85) begin
				k = $urandom_range(4, 40);
				queue_turn(k);
				n += k;
			end else begin
				add_sample($urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 3) == 0);
				n++;
			end
		end
	endtask

	// half the time a small value, else anything up to the wide bound
	function automatic logic [15:0] pick_value(int unsigned narrow, int unsigned wide);
		int unsigned v;
		v = $urandom_range(1) ? $urandom_range(0, narrow) : $urandom_range(0, wide);
		return 16'(v);
	endfunction

	task automatic random_config();
		write_reg(whtp_pkg::RegPropGain, pick_value(2047, 65535));
		write_reg(whtp_pkg::RegIntegGain, pick_value(255, 65535));
		write_reg(whtp_pkg::RegDerivGain, pick_value(4095, 65535));
		write_reg(whtp_pkg::RegIntegLimit, pick_value(4000, 65535));
		write_reg(whtp_pkg::RegTopSpeed, 16'($urandom_range(0, 127)));
		write_reg(whtp_pkg::RegSettleThresh, pick_value(64, 2880));
		write_reg(whtp_pkg::RegSettleLimit, pick_value(30, 1023));
		write_reg(whtp_pkg::RegTimeout, pick_value(40, 65535));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// wrap extremes, integration window edges, settle threshold edges
		add_sample(0, 0, 1'b1);
		add_sample(5759, 0, 1'b0);
		add_sample(0, 5759, 1'b0);
		add_sample(2880, 0, 1'b0);
		add_sample(0, 2880, 1'b0);
		add_sample(2879, 0, 1'b0);
		add_sample(8191, 0, 1'b0);
		add_sample(0, 8191, 1'b0);
		add_sample(8191, 8191, 1'b0);
		add_sample(479, 0, 1'b0);
		add_sample(480, 0, 1'b0);
		add_sample(0, 479, 1'b0);
		add_sample(0, 480, 1'b0);
		add_sample(15, 0, 1'b0);
		add_sample(16, 0, 1'b0);
		add_sample(0, 15, 1'b0);
		add_sample(0, 16, 1'b0);
		add_sample(1000, 900, 1'b1);
		add_sample(1000, 990, 1'b0);
		add_sample(1000, 1003, 1'b0);
		add_sample(4095, 4096, 1'b0);
		add_sample(5000, 6000, 1'b1);
		drain();

		random_config();
		queue_random(130);
		drain();

		// maximum gains, immediate done
		write_reg(whtp_pkg::RegPropGain, 16'hffff);
		write_reg(whtp_pkg::RegIntegGain, 16'hffff);
		write_reg(whtp_pkg::RegDerivGain, 16'hffff);
		write_reg(whtp_pkg::RegIntegLimit, 16'hffff);
		write_reg(whtp_pkg::RegTopSpeed, 16'd127);
		write_reg(whtp_pkg::RegSettleThresh, 16'd2880);
		write_reg(whtp_pkg::RegSettleLimit, 16'd0);
		write_reg(whtp_pkg::RegTimeout, 16'd0);
		queue_random(60);
		drain();

		// zero top speed and zero limits
		write_reg(whtp_pkg::RegPropGain, 16'd0);
		write_reg(whtp_pkg::RegIntegGain, 16'd0);
		write_reg(whtp_pkg::RegDerivGain, 16'd0);
		write_reg(whtp_pkg::RegIntegLimit, 16'd0);
		write_reg(whtp_pkg::RegTopSpeed, 16'd0);
		write_reg(whtp_pkg::RegSettleThresh, 16'd0);
		write_reg(whtp_pkg::RegSettleLimit, 16'd0);
		write_reg(whtp_pkg::RegTimeout, 16'd0);
		queue_random(40);
		drain();

		// settle count crosses its limit within one long move
		write_reg(whtp_pkg::RegPropGain, 16'd300);
		write_reg(whtp_pkg::RegIntegGain, 16'd40);
		write_reg(whtp_pkg::RegSettleThresh, 16'd2880);
		write_reg(whtp_pkg::RegSettleLimit, 16'd250);
		write_reg(whtp_pkg::RegTimeout, 16'hffff);
		write_reg(whtp_pkg::RegTopSpeed, 16'd100);
		steady = 1'b1;
		add_sample(100, 200, 1'b1);
		for (int i = 0; i < 300; i++)
			add_sample($urandom_range(0, 5759), $urandom_range(0, 5759), 1'b0);
		drain();
		steady = 1'b0;

		random_config();
		queue_random(130);
		drain();

		if (mismatches == 0)
			$display("wrapped_heading_turn_pid_tb passed");
		else
			$display("wrapped_heading_turn_pid_tb failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("wrapped_heading_turn_pid_tb failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/whtp_pkg.sv
rtl/wrapped_heading_turn_pid.sv
rtl/whtp_checker.sv
dv/wrapped_heading_turn_pid_tb.sv
